// ===== hw/rtl/deq_pkg.sv =====
package deq_pkg;

   localparam int DEPTH_DEFAULT = 16;

   localparam int KIND_W   = 3;
   localparam int VALUE_W  = 32;
   localparam int STATUS_W = 2;
   localparam int COUNT_W  = 5;

   typedef enum logic [KIND_W-1:0] {
      KIND_PUSH_BACK  = 3'd0,
      KIND_PUSH_FRONT = 3'd1,
      KIND_POP_FRONT  = 3'd2,
      KIND_POP_BACK   = 3'd3,
      KIND_CLEAR      = 3'd4
   } kind_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_OK    = 2'd0,
      ST_FULL  = 2'd1,
      ST_EMPTY = 2'd2
   } status_type;

   typedef enum logic [1:0] {
      S_IDLE,
      S_EXEC,
      S_FETCH,
      S_LOAD
   } state_type;

   // commands from the sequencer to the datapath
   typedef struct packed {
      logic capture;
      logic exec;
      logic fetch;
      logic load;
   } deq_cmd_type;

endpackage

// ===== hw/rtl/deq_if.sv =====
interface deq_req_if;
   import deq_pkg::*;

   logic                      valid;
   logic                      ready;
   logic [KIND_W-1:0]         kind;
   logic signed [VALUE_W-1:0] value;

   modport source (output valid, output kind, output value, input ready);
   modport sink   (input valid, input kind, input value, output ready);
endinterface

interface deq_rsp_if;
   import deq_pkg::*;

   logic                      valid;
   logic                      ready;
   logic [STATUS_W-1:0]       status;
   logic signed [VALUE_W-1:0] removed_value;
   logic signed [VALUE_W-1:0] front_value;
   logic signed [VALUE_W-1:0] back_value;
   logic [COUNT_W-1:0]        fill_count;

   modport source (output valid, output status, output removed_value, output front_value,
                   output back_value, output fill_count, input ready);
   modport sink   (input valid, input status, input removed_value, input front_value,
                   input back_value, input fill_count, output ready);
endinterface

// ===== hw/rtl/deq_ctrl.sv =====
module deq_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output deq_pkg::deq_cmd_type cmd
);
   import deq_pkg::*;

   state_type state_ff;
   state_type state_in;
   logic      rsp_valid_ff;
   logic      rsp_valid_in;
   logic      out_free;

   assign out_free = !rsp_valid_ff || rsp_ready;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) state_in = S_EXEC;
         end
         S_EXEC:  state_in = S_FETCH;
         S_FETCH: state_in = S_LOAD;
         S_LOAD: begin
            if (out_free) state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_comb begin
      req_ready   = (state_ff == S_IDLE);
      cmd.capture = (state_ff == S_IDLE) && req_valid;
      cmd.exec    = (state_ff == S_EXEC);
      cmd.fetch   = (state_ff == S_FETCH);
      cmd.load    = (state_ff == S_LOAD) && out_free;
      // hold the result until taken, refill from the load step
      rsp_valid_in = cmd.load ? 1'b1 : (rsp_valid_ff && !rsp_ready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

// ===== hw/rtl/deq_datapath.sv =====
module deq_datapath #(
   parameter int DEPTH = deq_pkg::DEPTH_DEFAULT
) (
   input  logic                          clock,
   input  logic                          reset,
   input  deq_pkg::deq_cmd_type          cmd,
   input  logic [deq_pkg::KIND_W-1:0]    req_kind,
   input  logic [deq_pkg::VALUE_W-1:0]   req_value,
   output logic [deq_pkg::STATUS_W-1:0]  rsp_status,
   output logic [deq_pkg::VALUE_W-1:0]   rsp_removed_value,
   output logic [deq_pkg::VALUE_W-1:0]   rsp_front_value,
   output logic [deq_pkg::VALUE_W-1:0]   rsp_back_value,
   output logic [deq_pkg::COUNT_W-1:0]   rsp_fill_count
);
   import deq_pkg::*;

   localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(DEPTH - 1);
   localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

   function automatic logic [IDX_W-1:0] ring_next(input logic [IDX_W-1:0] idx);
      return (idx == LAST_IDX) ? '0 : idx + IDX_W'(1);
   endfunction

   function automatic logic [IDX_W-1:0] ring_prev(input logic [IDX_W-1:0] idx);
      return (idx == '0) ? LAST_IDX : idx - IDX_W'(1);
   endfunction

   logic [VALUE_W-1:0]  store_mem [DEPTH];

   logic [KIND_W-1:0]   kind_ff;
   logic [VALUE_W-1:0]  value_ff;
   logic [IDX_W-1:0]    front_ff, front_in;
   logic [IDX_W-1:0]    back_ff, back_in;
   logic [CNT_W-1:0]    count_ff, count_in;
   logic [STATUS_W-1:0] status_ff, status_in;
   logic                pop_ok_ff, pop_ok_in;
   logic                wr_en;
   logic [IDX_W-1:0]    wr_addr;
   logic [IDX_W-1:0]    pop_addr;
   logic [IDX_W-1:0]    rd_addr_a;
   logic [IDX_W-1:0]    rd_addr_b;
   logic [VALUE_W-1:0]  rd_a_ff;
   logic [VALUE_W-1:0]  rd_b_ff;
   logic [VALUE_W-1:0]  removed_ff;
   logic                full;
   logic                empty;
   logic                nonempty;
   logic [CNT_W+COUNT_W-1:0] count_ext;

   logic [STATUS_W-1:0] rsp_status_ff;
   logic [VALUE_W-1:0]  rsp_removed_ff;
   logic [VALUE_W-1:0]  rsp_front_ff;
   logic [VALUE_W-1:0]  rsp_back_ff;
   logic [COUNT_W-1:0]  rsp_fill_ff;

   assign full     = (count_ff == FULL_CNT);
   assign empty    = (count_ff == '0);
   assign nonempty = !empty;

   always_comb begin
      front_in  = front_ff;
      back_in   = back_ff;
      count_in  = count_ff;
      status_in = ST_OK;
      pop_ok_in = 1'b0;
      wr_en     = 1'b0;
      wr_addr   = back_ff;
      pop_addr  = front_ff;
      unique case (kind_type'(kind_ff))
         KIND_PUSH_BACK: begin
            if (full) begin
               status_in = ST_FULL;
            end else begin
               wr_en    = 1'b1;
               wr_addr  = back_ff;
               back_in  = ring_next(back_ff);
               count_in = count_ff + CNT_W'(1);
            end
         end
         KIND_PUSH_FRONT: begin
            if (full) begin
               status_in = ST_FULL;
            end else begin
               wr_en    = 1'b1;
               wr_addr  = ring_prev(front_ff);
               front_in = ring_prev(front_ff);
               count_in = count_ff + CNT_W'(1);
            end
         end
         KIND_POP_FRONT: begin
            if (empty) begin
               status_in = ST_EMPTY;
            end else begin
               pop_ok_in = 1'b1;
               pop_addr  = front_ff;
               front_in  = ring_next(front_ff);
               count_in  = count_ff - CNT_W'(1);
            end
         end
         KIND_POP_BACK: begin
            if (empty) begin
               status_in = ST_EMPTY;
            end else begin
               pop_ok_in = 1'b1;
               pop_addr  = ring_prev(back_ff);
               back_in   = ring_prev(back_ff);
               count_in  = count_ff - CNT_W'(1);
            end
         end
         KIND_CLEAR: begin
            front_in = '0;
            back_in  = '0;
            count_in = '0;
         end
         default: begin
         end
      endcase
   end

   // read the popped entry during exec, then front and back
   assign rd_addr_a = cmd.exec ? pop_addr : front_ff;
   assign rd_addr_b = ring_prev(back_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         front_ff <= '0;
         back_ff  <= '0;
         count_ff <= '0;
      end else if (cmd.exec) begin
         front_ff <= front_in;
         back_ff  <= back_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.exec && wr_en) begin
         store_mem[wr_addr] <= value_ff;
      end
      rd_a_ff <= store_mem[rd_addr_a];
      rd_b_ff <= store_mem[rd_addr_b];
   end

   assign count_ext = {{COUNT_W{1'b0}}, count_ff};

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         kind_ff  <= req_kind;
         value_ff <= req_value;
      end
      if (cmd.exec) begin
         status_ff <= status_in;
         pop_ok_ff <= pop_ok_in;
      end
      if (cmd.fetch) begin
         removed_ff <= pop_ok_ff ? rd_a_ff : '0;
      end
      if (cmd.load) begin
         rsp_status_ff  <= status_ff;
         rsp_removed_ff <= removed_ff;
         rsp_front_ff   <= nonempty ? rd_a_ff : '0;
         rsp_back_ff    <= nonempty ? rd_b_ff : '0;
         rsp_fill_ff    <= count_ext[COUNT_W-1:0];
      end
   end

   assign rsp_status        = rsp_status_ff;
   assign rsp_removed_value = rsp_removed_ff;
   assign rsp_front_value   = rsp_front_ff;
   assign rsp_back_value    = rsp_back_ff;
   assign rsp_fill_count    = rsp_fill_ff;

endmodule

// ===== hw/rtl/double_ended_queue_top.sv =====
// Bounded double-ended queue over a ring store of DEPTH entries.
// Request channel (req_ch): one transaction carries an operation kind (push back,
// push front, pop front, pop back, clear) and a value used by pushes.
// Response channel (rsp_ch): exactly one transaction per request, in order, with
// the status (ok, full, empty), the popped value, the front and back values after
// the operation and the fill count. Refused pushes and pops change nothing.
// After a request is accepted it walks the exec, fetch and load steps, and the
// load step fills the response register; a new request is taken only once the
// last one has left its load step. The steps are needed because the store has
// registered read ports and is read twice (popped entry, then front and back).
// The response sits in an output register; while it waits, the next request is
// already taken and worked on, and only its load step waits for the register.
// A stalled receiver therefore holds at most one finished and one pending result.
// Reset (synchronous, active high) empties the queue and drops any pending
// response; the store contents are not cleared, since entries are only read
// after being written.
module double_ended_queue_top #(
   parameter int DEPTH = deq_pkg::DEPTH_DEFAULT
) (
   input logic        clock,
   input logic        reset,
   deq_req_if.sink    req_ch,
   deq_rsp_if.source  rsp_ch
);
   import deq_pkg::*;

   deq_cmd_type         cmd;
   logic                req_valid;
   logic                req_ready;
   logic                rsp_valid;
   logic                rsp_ready;
   logic [STATUS_W-1:0] rsp_status;
   logic [VALUE_W-1:0]  rsp_removed_value;
   logic [VALUE_W-1:0]  rsp_front_value;
   logic [VALUE_W-1:0]  rsp_back_value;
   logic [COUNT_W-1:0]  rsp_fill_count;

   assign req_valid    = req_ch.valid;
   assign req_ch.ready = req_ready;
   assign rsp_ready    = rsp_ch.ready;
   assign rsp_ch.valid = rsp_valid;

   // sequence each transaction through exec, fetch and load
   deq_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .cmd       (cmd)
   );

   // pointers, count, ring store and the response register
   deq_datapath #(
      .DEPTH (DEPTH)
   ) u_datapath (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .req_kind          (req_ch.kind),
      .req_value         (req_ch.value),
      .rsp_status        (rsp_status),
      .rsp_removed_value (rsp_removed_value),
      .rsp_front_value   (rsp_front_value),
      .rsp_back_value    (rsp_back_value),
      .rsp_fill_count    (rsp_fill_count)
   );

   assign rsp_ch.status        = rsp_status;
   assign rsp_ch.removed_value = rsp_removed_value;
   assign rsp_ch.front_value   = rsp_front_value;
   assign rsp_ch.back_value    = rsp_back_value;
   assign rsp_ch.fill_count    = rsp_fill_count;

endmodule

// ===== hw/rtl/deq_checker.sv =====
module deq_checker #(
   parameter int DEPTH = deq_pkg::DEPTH_DEFAULT
) (
   input logic                          clock,
   input logic                          reset,
   input logic                          req_valid,
   input logic                          req_ready,
   input logic                          rsp_valid,
   input logic                          rsp_ready,
   input logic [deq_pkg::STATUS_W-1:0]  rsp_status,
   input logic [deq_pkg::VALUE_W-1:0]   rsp_removed_value,
   input logic [deq_pkg::VALUE_W-1:0]   rsp_front_value,
   input logic [deq_pkg::VALUE_W-1:0]   rsp_back_value,
   input logic [deq_pkg::COUNT_W-1:0]   rsp_fill_count
);
   import deq_pkg::*;

   localparam bit COUNT_EXACT = (DEPTH < (1 << COUNT_W));

   // one request in flight: no back-to-back accepts
   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !req_ready)
      else $error("request accepted in consecutive cycles");

   // a refused pop only happens on an empty queue and removes nothing
   a_empty_pop: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status == ST_EMPTY) |->
         (rsp_removed_value == '0 && rsp_fill_count == '0))
      else $error("empty pop reported a value or a nonzero count");

   // an empty queue shows zero front and back
   a_empty_ends: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && COUNT_EXACT && rsp_fill_count == '0) |->
         (rsp_front_value == '0 && rsp_back_value == '0))
      else $error("empty queue reported front or back value");

   // the count never goes beyond the store depth
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && COUNT_EXACT) |-> (32'(rsp_fill_count) <= 32'(DEPTH)))
      else $error("fill count beyond depth");

   // a stalled response holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=>
         (rsp_valid && $stable(rsp_status) && $stable(rsp_removed_value) &&
          $stable(rsp_front_value) && $stable(rsp_back_value) &&
          $stable(rsp_fill_count)))
      else $error("stalled response changed");

endmodule

bind double_ended_queue_top deq_checker #(
   .DEPTH (DEPTH)
) u_deq_checker (
   .clock             (clock),
   .reset             (reset),
   .req_valid         (req_valid),
   .req_ready         (req_ready),
   .rsp_valid         (rsp_valid),
   .rsp_ready         (rsp_ready),
   .rsp_status        (rsp_status),
   .rsp_removed_value (rsp_removed_value),
   .rsp_front_value   (rsp_front_value),
   .rsp_back_value    (rsp_back_value),
   .rsp_fill_count    (rsp_fill_count)
);
